### rtl/bht_pkg.sv
// bht_pkg: types, sizes and codes shared by the bucketed hash table
// depends on nothing; used by bucketed_hash_table

`default_nettype none

package bht_pkg;

    localparam int unsigned BUCKETS = 31;
    localparam int unsigned WAYS    = 8;
    localparam int unsigned SLOTS   = BUCKETS * WAYS;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VAL_W   = 64;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned TOT_W   = 8;

    localparam int unsigned BKT_W   = $clog2(BUCKETS);
    localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

    // reciprocal for the bucket reduction: floor(2^KEY_W / BUCKETS)
    localparam logic [KEY_W-1:0] BKT_DIV = KEY_W'(BUCKETS);
    localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / BUCKETS);
    localparam logic [KEY_W-1:0] HASH_MUL = KEY_W'(5);

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERO    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  found_value;
        logic [TOT_W-1:0]  entry_total;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    typedef slot_t [WAYS-1:0] row_t;

    localparam int unsigned ROW_W = $bits(row_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_UPDATE
    } state_t;

endpackage

`default_nettype wire

### rtl/bucketed_hash_table.sv
// bucketed_hash_table: key-to-value map, one bucket row of ways per hash bucket
// depends on bht_pkg and bht_ram
//
//   channel  dir  handshake          payload
//   s_       in   s_valid / s_ready  bht_pkg::in_item_t  (op, key, value)
//   m_       out  m_valid / m_ready  bht_pkg::out_item_t (status, found_value, entry_total)
//
// per item: hash multiply ahead of the accepting edge, bucket reduction and row read in the
// next cycle, compare and write-back of the row after; a new item is taken as the last finishes.
// the bucket row comes from the registered ram read.
// reset clears all slot valid bits and the entry count together, no sweep.
// a result waiting in the output register holds the compare stage, and with it the input.

`default_nettype none

module bucketed_hash_table (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bht_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bht_pkg::out_item_t      m_item
);

    bht_pkg::state_t                 state_reg, state_next;
    bht_pkg::in_item_t               in_reg;
    logic [bht_pkg::KEY_W-1:0]       hx_reg, hx_next;
    logic [bht_pkg::KEY_W-1:0]       q_reg, q_next;
    logic [2*bht_pkg::KEY_W-1:0]     prod;
    logic [bht_pkg::BKT_W-1:0]       bucket_reg, bucket_next;
    logic [bht_pkg::KEY_W-1:0]       qb, rem0, rem1;
    logic [bht_pkg::WAYS-1:0]        valid_reg [bht_pkg::BUCKETS];
    logic [bht_pkg::CNT_W-1:0]       count_reg, count_next;
    bht_pkg::out_item_t              out_reg, out_next;
    logic                            out_valid_reg;

    logic                            accept, advance, rd_en;
    bht_pkg::row_t                   rd_row, wr_row;
    logic [bht_pkg::WAYS-1:0]        row_vld, hit_vec, free_vec;
    logic [bht_pkg::WAY_W-1:0]       hit_idx, free_idx;
    logic                            any_hit, any_free, do_insert, do_remove;

    // hash: key*5 wrapped, then reciprocal estimate of the quotient
    always_comb begin
        hx_next = s_item.key * bht_pkg::HASH_MUL;
        prod    = {{bht_pkg::KEY_W{1'b0}}, hx_next} * {{bht_pkg::KEY_W{1'b0}}, bht_pkg::RECIP};
        q_next  = prod[2*bht_pkg::KEY_W-1:bht_pkg::KEY_W];
    end

    // remainder correction, estimate is at most one low
    always_comb begin
        qb          = q_reg * bht_pkg::BKT_DIV;
        rem0        = hx_reg - qb;
        rem1        = (rem0 >= bht_pkg::BKT_DIV) ? (rem0 - bht_pkg::BKT_DIV) : rem0;
        bucket_next = rem1[bht_pkg::BKT_W-1:0];
    end

    // fsm next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bht_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = bht_pkg::S_CALC;
                end
            end
            bht_pkg::S_CALC: begin
                state_next = bht_pkg::S_UPDATE;
            end
            bht_pkg::S_UPDATE: begin
                if (advance) begin
                    state_next = accept ? bht_pkg::S_CALC : bht_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bht_pkg::S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        advance = 1'b0;
        s_ready = 1'b0;
        rd_en   = 1'b0;
        unique case (state_reg)
            bht_pkg::S_IDLE: begin
                s_ready = 1'b1;
            end
            bht_pkg::S_CALC: begin
                rd_en = 1'b1;
            end
            bht_pkg::S_UPDATE: begin
                advance = !out_valid_reg || m_ready;
                s_ready = advance;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    bht_ram #(
        .WIDTH (bht_pkg::ROW_W),
        .DEPTH (bht_pkg::BUCKETS)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (advance && do_insert),
        .wr_addr (bucket_reg),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (bucket_next),
        .rd_data (rd_row)
    );

    // way compare and priority pick, lowest way wins
    always_comb begin
        row_vld  = valid_reg[bucket_reg];
        hit_vec  = '0;
        free_vec = '0;
        hit_idx  = '0;
        free_idx = '0;
        for (int w = bht_pkg::WAYS - 1; w >= 0; w--) begin
            hit_vec[w]  = row_vld[w] && (rd_row[w].key == in_reg.key);
            free_vec[w] = !row_vld[w];
            if (hit_vec[w]) begin
                hit_idx = bht_pkg::WAY_W'(w);
            end
            if (free_vec[w]) begin
                free_idx = bht_pkg::WAY_W'(w);
            end
        end
        any_hit  = |hit_vec;
        any_free = |free_vec;
    end

    // operation result
    always_comb begin
        out_next             = '0;
        do_insert            = 1'b0;
        do_remove            = 1'b0;
        out_next.status      = bht_pkg::ST_OK;
        wr_row               = rd_row;
        wr_row[free_idx]     = '{key: in_reg.key, value: in_reg.value};
        unique case (in_reg.op)
            bht_pkg::OP_LOOKUP: begin
                if (any_hit) begin
                    out_next.found_value = rd_row[hit_idx].value;
                end else begin
                    out_next.status = bht_pkg::ST_ABSENT;
                end
            end
            bht_pkg::OP_INSERT: begin
                if (in_reg.value == '0) begin
                    out_next.status = bht_pkg::ST_ZERO;
                end else if (any_hit) begin
                    out_next.status = bht_pkg::ST_PRESENT;
                end else if (!any_free) begin
                    out_next.status = bht_pkg::ST_FULL;
                end else begin
                    do_insert = 1'b1;
                end
            end
            bht_pkg::OP_REMOVE: begin
                if (any_hit) begin
                    do_remove = 1'b1;
                end else begin
                    out_next.status = bht_pkg::ST_ABSENT;
                end
            end
            default: begin
                out_next.status = bht_pkg::ST_OK;
            end
        endcase
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + bht_pkg::CNT_W'(1);
        end else if (do_remove) begin
            count_next = count_reg - bht_pkg::CNT_W'(1);
        end
        out_next.entry_total = bht_pkg::TOT_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bht_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < bht_pkg::BUCKETS; b++) begin
                valid_reg[b] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (advance) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                if (do_insert) begin
                    valid_reg[bucket_reg][free_idx] <= 1'b1;
                end
                if (do_remove) begin
                    valid_reg[bucket_reg][hit_idx] <= 1'b0;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_item;
            hx_reg <= hx_next;
            q_reg  <= q_next;
        end
        if (state_reg == bht_pkg::S_CALC) begin
            bucket_reg <= bucket_next;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bht_pkg::CNT_W'(bht_pkg::SLOTS))
        else $error("entry count above slot total");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bht_pkg::S_UPDATE) |-> $onehot0(hit_vec))
        else $error("key held by more than one way");

    a_calc_then_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bht_pkg::S_CALC) |=> (state_reg == bht_pkg::S_UPDATE))
        else $error("row read not followed by compare");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && do_insert) |=> (count_reg == $past(count_reg) + bht_pkg::CNT_W'(1)))
        else $error("insert did not raise entry count");

    a_result_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("finished item left no result");

endmodule

`default_nettype wire

### rtl/bht_ram.sv
// bht_ram: generic single-clock ram, one write port and one registered read port
// depends on nothing

`default_nettype none

module bht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [WIDTH-1:0]          wr_data,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
